### sv/plar_pkg.sv
// ----------------------------------------------------------------------------
// plar_pkg
// Shared types, register codes and constants for the polyphase / linear
// audio resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package plar_pkg;

    // Coefficient store: 128 rows of four taps.
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned COEF_DEPTH = 512;
    localparam int unsigned COEF_AW    = 9;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam logic        REG_STEP_RATIO  = 1'b0;
    localparam logic        REG_INTERP_MODE = 1'b1;

    localparam logic [31:0] MIN_RATIO   = 32'd1024;
    localparam logic [31:0] RESET_RATIO = 32'h0001_0000;
    localparam logic [16:0] PHASE_ONE   = 17'h1_0000;

    // Interpolation modes; the unused code 3 renders as linear
    localparam logic [1:0] MODE_POLY   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    // Operation codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    localparam int unsigned POLY_SHIFT = 15;
    localparam int unsigned LIN_SHIFT  = 16;

    // MAC sequence: reads on counts 0..3, products on 1..4, sums on 2..5
    localparam logic [2:0] MAC_LAST = 3'd5;

    typedef struct packed {
        logic                      operation;
        logic [COEF_AW-1:0]        coef_index;
        logic signed [15:0]        coef_value;
        logic signed [15:0]        source_sample;
    } src_item_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               last_of_run;
    } res_item_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_DIRECT,
        CMD_RENDER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [COEF_AW-1:0] coef_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] sample;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_MAC,
        ST_EMIT,
        ST_SHIFT,
        ST_DIRECT
    } back_state_t;

endpackage

`default_nettype wire

### sv/plar_ram.sv
// ----------------------------------------------------------------------------
// plar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plar_ram #(
    parameter int unsigned WIDTH = plar_pkg::COEF_W,
    parameter int unsigned DEPTH = plar_pkg::COEF_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/plar_fifo.sv
// ----------------------------------------------------------------------------
// plar_fifo
// Short command queue between the front and the back of the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

module plar_fifo #(
    parameter int unsigned DEPTH = plar_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire plar_pkg::cmd_t     push_data,
    input  wire logic               pop,
    output plar_pkg::cmd_t          head,
    output plar_pkg::q_flags_t      flags
);

    import plar_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign flags.full  = (count_reg == FULL_COUNT);
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/plar_front.sv
// ----------------------------------------------------------------------------
// plar_front
// Input stage: takes source items, sorts them into coefficient loads,
// direct pushes and rendering pushes, and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plar_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           interp_mode,
    input  wire logic                 src_valid,
    output logic                      src_stall,
    input  wire plar_pkg::src_item_t  src_item,
    input  wire plar_pkg::q_flags_t   q_flags,
    output logic                      q_push,
    output plar_pkg::cmd_t            q_data
);

    import plar_pkg::*;

    logic held_reg, held_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    assign src_stall = held_reg && q_flags.full;
    assign accept    = src_valid && !src_stall;
    assign q_push    = held_reg && !q_flags.full;
    assign q_data    = cmd_reg;

    always_comb
    begin
        cmd_next.coef_index = src_item.coef_index;
        cmd_next.coef_value = src_item.coef_value;
        cmd_next.sample     = src_item.source_sample;
        if (src_item.operation == OP_LOAD)
        begin
            cmd_next.kind = CMD_LOAD;
        end
        else if (interp_mode == MODE_DIRECT)
        begin
            cmd_next.kind = CMD_DIRECT;
        end
        else
        begin
            cmd_next.kind = CMD_RENDER;
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (accept)
        begin
            held_next = 1'b1;
        end
        else if (q_push)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    // hold the payload until the queue takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

### sv/plar_back.sv
// ----------------------------------------------------------------------------
// plar_back
// Execution side: coefficient store, sample history, phase accumulator and
// one shared multiply-accumulate unit that renders the due outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module plar_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [31:0]          step_ratio,
    input  wire logic [1:0]           interp_mode,
    input  wire plar_pkg::cmd_t       q_head,
    input  wire plar_pkg::q_flags_t   q_flags,
    output logic                      q_pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output plar_pkg::res_item_t       res_item
);

    import plar_pkg::*;

    back_state_t          state_reg, state_next;
    logic signed [15:0]   hist_reg [4];
    logic signed [15:0]   hist_next [4];
    logic [15:0]          phase_reg, phase_next;
    logic [16:0]          pending_reg, pending_next;
    logic                 started_reg, started_next;
    logic [2:0]           mac_cnt_reg, mac_cnt_next;
    logic signed [33:0]   product_reg, product_next;
    logic signed [34:0]   acc_reg, acc_next;
    logic signed [15:0]   sample_reg;
    logic                 res_valid_reg, res_valid_next;
    res_item_t            res_item_reg, res_item_next;

    logic                 ram_we;
    logic [COEF_AW-1:0]   ram_raddr;
    logic [COEF_W-1:0]    ram_rdata;

    logic                 out_free;
    logic                 do_advance, do_shift, do_emit, do_direct;
    logic                 set_started, mac_clear, mac_step;
    logic [32:0]          phase_sum;
    logic [1:0]           tap_sel;
    logic signed [15:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic [16:0]          lin_w0;
    logic signed [34:0]   acc_shifted;
    logic signed [15:0]   render_value;

    function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
        logic signed [15:0] r;
        if (v > 35'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -35'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    plar_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_head.coef_index),
        .wdata (q_head.coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_ratio};
    assign ram_raddr = {phase_reg[15:9], mac_cnt_reg[1:0]};

    // MAC operands: tap t is read at count t and multiplied at count t+1
    assign tap_sel = mac_cnt_reg[1:0] - 2'd1;
    assign mul_a   = hist_reg[tap_sel];
    assign lin_w0  = PHASE_ONE - {1'b0, phase_reg};

    always_comb
    begin
        if (interp_mode == MODE_POLY)
        begin
            mul_b = {{2{ram_rdata[COEF_W-1]}}, ram_rdata};
        end
        else if (tap_sel == 2'd0)
        begin
            mul_b = {1'b0, lin_w0};
        end
        else if (tap_sel == 2'd1)
        begin
            mul_b = {2'b00, phase_reg};
        end
        else
        begin
            mul_b = '0;
        end
    end

    assign product_next = mul_a * mul_b;
    assign acc_shifted  = (interp_mode == MODE_POLY) ? (acc_reg >>> POLY_SHIFT)
                                                     : (acc_reg >>> LIN_SHIFT);
    assign render_value = sat16(acc_shifted);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_flags.empty)
                begin
                    case (q_head.kind)
                        CMD_DIRECT: state_next = ST_DIRECT;
                        CMD_RENDER: state_next = started_reg ? ST_CHECK : ST_START;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:  state_next = ST_CHECK;
            ST_CHECK:  state_next = (pending_reg == '0) ? ST_MAC : ST_SHIFT;
            ST_MAC:    state_next = (mac_cnt_reg == MAC_LAST) ? ST_EMIT : ST_MAC;
            ST_EMIT:   state_next = out_free ? ST_CHECK : ST_EMIT;
            ST_SHIFT:  state_next = ST_IDLE;
            ST_DIRECT: state_next = out_free ? ST_IDLE : ST_DIRECT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        do_advance  = 1'b0;
        do_shift    = 1'b0;
        do_emit     = 1'b0;
        do_direct   = 1'b0;
        set_started = 1'b0;
        mac_clear   = 1'b0;
        mac_step    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop  = !q_flags.empty;
                ram_we = !q_flags.empty && (q_head.kind == CMD_LOAD);
            end
            ST_START:
            begin
                do_advance  = 1'b1;
                set_started = 1'b1;
            end
            ST_CHECK:  mac_clear = (pending_reg == '0);
            ST_MAC:    mac_step  = 1'b1;
            ST_EMIT:
            begin
                do_emit    = out_free;
                do_advance = out_free;
            end
            ST_SHIFT:  do_shift = 1'b1;
            ST_DIRECT:
            begin
                do_direct = out_free;
                do_shift  = out_free;
            end
            default:   q_pop = 1'b0;
        endcase
    end

    // datapath next values
    always_comb
    begin
        hist_next      = hist_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        started_next   = started_reg || set_started;
        mac_cnt_next   = mac_cnt_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;

        if (do_advance)
        begin
            pending_next = phase_sum[32:16];
            phase_next   = phase_sum[15:0];
        end
        if (do_shift)
        begin
            hist_next[0] = hist_reg[1];
            hist_next[1] = hist_reg[2];
            hist_next[2] = hist_reg[3];
            hist_next[3] = sample_reg;
            if (!do_direct && (pending_reg != '0))
            begin
                pending_next = pending_reg - 17'd1;
            end
        end
        if (mac_clear)
        begin
            mac_cnt_next = '0;
            acc_next     = '0;
        end
        if (mac_step)
        begin
            mac_cnt_next = mac_cnt_reg + 3'd1;
            if (mac_cnt_reg >= 3'd2)
            begin
                acc_next = acc_reg + {product_reg[33], product_reg};
            end
        end
        if (do_emit)
        begin
            res_valid_next            = 1'b1;
            res_item_next.out_sample  = render_value;
            // last when the advance leaves a sample still owed
            res_item_next.last_of_run = (phase_sum[32:16] != '0);
        end
        if (do_direct)
        begin
            res_valid_next            = 1'b1;
            res_item_next.out_sample  = sample_reg;
            res_item_next.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hist_reg      <= '{default: '0};
            phase_reg     <= '0;
            pending_reg   <= '0;
            started_reg   <= 1'b0;
            mac_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            started_reg   <= started_next;
            mac_cnt_reg   <= mac_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= q_head.sample;
        end
        if (mac_step && (mac_cnt_reg >= 3'd1) && (mac_cnt_reg <= 3'd4))
        begin
            product_reg <= product_next;
        end
        acc_reg      <= acc_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

### sv/polyphase_linear_audio_resampler.sv
// Coefficient load: written to the coefficient RAM when the back pops it.
// Direct push: the back registers its sample as a result once the output is free.
// Rendering push: the back renders each due output with its MAC sequence (the first
// push also starts the phase accumulator); up to 64 outputs per sample.
// Reset (rst_n low, async): clears history, phase, pending count, started flag,
// queue and config registers; coefficient RAM keeps its contents.
// ----------------------------------------------------------------------------
// polyphase_linear_audio_resampler
// Push-driven sample-rate converter: four-tap polyphase, linear or direct
// pass-through, with a front classifier, a command queue and a render back.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_linear_audio_resampler #(
    parameter int unsigned QUEUE_DEPTH = plar_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [plar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [plar_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               src_valid,
    output logic                                    src_stall,
    input  wire plar_pkg::src_item_t                src_item,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output plar_pkg::res_item_t                     res_item
);

    import plar_pkg::*;

    logic [31:0] step_ratio_reg, step_ratio_next;
    logic [1:0]  interp_mode_reg, interp_mode_next;

    logic        q_push, q_pop;
    cmd_t        q_data, q_head;
    q_flags_t    q_flags;

    // clamp the ratio so one sample never owes more than 64 outputs
    always_comb
    begin
        step_ratio_next  = step_ratio_reg;
        interp_mode_next = interp_mode_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_STEP_RATIO:
                    step_ratio_next = (cfg_data < MIN_RATIO) ? MIN_RATIO : cfg_data;
                REG_INTERP_MODE:
                    interp_mode_next = cfg_data[1:0];
                default:
                    step_ratio_next = step_ratio_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg  <= RESET_RATIO;
            interp_mode_reg <= MODE_POLY;
        end
        else
        begin
            step_ratio_reg  <= step_ratio_next;
            interp_mode_reg <= interp_mode_next;
        end
    end

    plar_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .interp_mode (interp_mode_reg),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .q_flags     (q_flags),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    plar_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .flags     (q_flags)
    );

    plar_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_ratio  (step_ratio_reg),
        .interp_mode (interp_mode_reg),
        .q_head      (q_head),
        .q_flags     (q_flags),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_flags.full)
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_flags.empty)
        else $error("queue read while empty");

    a_ratio_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        step_ratio_reg >= MIN_RATIO)
        else $error("step ratio below minimum");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> q_flags.full)
        else $error("input stalled with room in queue");

endmodule

`default_nettype wire
